### rtl/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared constants and helpers for the link cell deframer.
// ----------------------------------------------------------------------------
package lcd_pkg;

    localparam int unsigned FIXED_PAYLOAD_BYTES = 509;
    localparam logic [15:0] FIXED_LEN           = 16'(FIXED_PAYLOAD_BYTES);

    localparam logic [15:0] LINK_VERSION_RESET  = 16'd4;
    localparam logic [15:0] LONG_CID_VERSION    = 16'd4;
    localparam logic [15:0] LONG_CID_BYTES      = 16'd4;
    localparam logic [15:0] SHORT_CID_BYTES     = 16'd2;

    localparam logic [7:0]  CMD_VAR_LOW         = 8'd7;
    localparam logic [7:0]  CMD_VAR_HIGH_MIN    = 8'd128;

    localparam logic        REC_HEADER          = 1'b0;
    localparam logic        REC_PAYLOAD         = 1'b1;

    function automatic logic cmd_is_variable(input logic [7:0] cmd);
        return (cmd == CMD_VAR_LOW) || (cmd >= CMD_VAR_HIGH_MIN);
    endfunction

endpackage

### rtl/link_cell_deframer_unit.sv
// ----------------------------------------------------------------------------
// link_cell_deframer_unit
// Splits a link byte stream into cells: one header item per cell, then one
// item per payload byte, with the final item of each cell marked.
// ----------------------------------------------------------------------------
// Output: each result is registered in the output register when the byte
//   that completes it is accepted.
// Throughput: one byte per cycle while a held result is taken or none is held;
//   the parser state and the output register are both updated in that single cycle.
// Reset: rst_n clears the parser to the circuit id phase, the version register to 4.
// ----------------------------------------------------------------------------
module link_cell_deframer_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        record_kind,
    output logic [31:0] cell_cid,
    output logic [7:0]  cell_command,
    output logic [15:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        last_of_cell
);

    typedef enum logic [1:0] {
        PH_CID,
        PH_CMD,
        PH_LEN,
        PH_PAY
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [15:0] count_reg,   count_next;
    logic [31:0] cid_reg,     cid_next;
    logic [7:0]  cmd_reg,     cmd_next;
    logic [15:0] len_reg,     len_next;
    logic [15:0] version_reg;

    logic        out_valid_reg;
    logic        kind_reg,    kind_next;
    logic [7:0]  pbyte_reg,   pbyte_next;
    logic        last_reg,    last_next;
    logic        emit;

    logic        in_fire;
    logic [15:0] id_len;
    logic [15:0] count_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    assign id_len    = (version_reg >= lcd_pkg::LONG_CID_VERSION) ?
                       lcd_pkg::LONG_CID_BYTES : lcd_pkg::SHORT_CID_BYTES;
    assign count_inc = count_reg + 16'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        cid_next   = cid_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        kind_next  = lcd_pkg::REC_HEADER;
        pbyte_next = 8'd0;
        last_next  = 1'b0;
        case (phase_reg)
            PH_CMD:
            begin
                cmd_next   = data_byte;
                count_next = 16'd0;
                if (lcd_pkg::cmd_is_variable(data_byte))
                begin
                    phase_next = PH_LEN;
                end
                else
                begin
                    len_next   = lcd_pkg::FIXED_LEN;
                    emit       = 1'b1;
                    phase_next = PH_PAY;
                end
            end
            PH_LEN:
            begin
                if (count_reg == 16'd0)
                begin
                    len_next   = {data_byte, 8'd0};
                    count_next = 16'd1;
                end
                else
                begin
                    len_next   = {len_reg[15:8], data_byte};
                    emit       = 1'b1;
                    count_next = 16'd0;
                    last_next  = ({len_reg[15:8], data_byte} == 16'd0);
                    phase_next = last_next ? PH_CID : PH_PAY;
                end
            end
            PH_PAY:
            begin
                emit       = 1'b1;
                kind_next  = lcd_pkg::REC_PAYLOAD;
                pbyte_next = data_byte;
                if (count_inc >= len_reg)
                begin
                    last_next  = 1'b1;
                    phase_next = PH_CID;
                    count_next = 16'd0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                cid_next = (count_reg == 16'd0) ? {24'd0, data_byte} :
                                                  {cid_reg[23:0], data_byte};
                if (count_inc >= id_len)
                begin
                    phase_next = PH_CMD;
                    count_next = 16'd0;
                end
                else
                begin
                    phase_next = PH_CID;
                    count_next = count_inc;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg   <= lcd_pkg::LINK_VERSION_RESET;
            phase_reg     <= PH_CID;
            count_reg     <= 16'd0;
            cid_reg       <= 32'd0;
            cmd_reg       <= 8'd0;
            len_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                version_reg <= cfg_data;
            end
            if (in_fire)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                cid_reg   <= cid_next;
                cmd_reg   <= cmd_next;
                len_reg   <= len_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            kind_reg  <= kind_next;
            pbyte_reg <= pbyte_next;
            last_reg  <= last_next;
        end
    end

    // header fields follow the held cell state
    logic [31:0] ocid_reg;
    logic [7:0]  ocmd_reg;
    logic [15:0] olen_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            ocid_reg <= cid_next;
            ocmd_reg <= cmd_next;
            olen_reg <= len_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign record_kind    = kind_reg;
    assign cell_cid       = ocid_reg;
    assign cell_command   = ocmd_reg;
    assign payload_length = olen_reg;
    assign payload_byte   = pbyte_reg;
    assign last_of_cell   = last_reg;

    a_header_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && record_kind == lcd_pkg::REC_HEADER && last_of_cell)
            |-> (payload_length == 16'd0))
        else $error("header marked last with nonzero length");

    a_payload_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_PAY) |=> out_valid_reg)
        else $error("payload byte produced no item");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while result stalled");

    a_cid_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_CID) |-> (count_reg < lcd_pkg::LONG_CID_BYTES))
        else $error("circuit id byte count out of range");

    a_pay_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (count_reg < len_reg))
        else $error("payload count reached length");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: link cell deframer
// Feeds framed cells (both circuit id widths, fixed and variable commands,
// empty and long payloads) plus loose noise bytes into the deframer under
// random valid/ready idling. Link version changes land at cell edges, mid-id and mid-cell.
// A scoreboard parses the same byte stream and checks every output item.
// ----------------------------------------------------------------------------
module testbench;

    typedef enum logic [1:0] {PH_CIRCUIT, PH_COMMAND, PH_LENGTH, PH_PAYLOAD} parse_phase_t;

    typedef struct {
        logic        kind;
        logic [31:0] cid;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic [7:0]  pbyte;
        logic        last;
    } cell_item_t;

    function automatic bit is_var_cmd(input logic [7:0] c);
        return (c == lcd_pkg::CMD_VAR_LOW) || c[7];
    endfunction

    class deframe_scoreboard;
        logic [15:0]  cur_version;
        parse_phase_t phase;
        logic [15:0]  count;
        logic [31:0]  cid;
        logic [7:0]   cmd;
        logic [15:0]  len;
        cell_item_t   due_items[$];
        int           errors;

        function new();
            cur_version  = lcd_pkg::LINK_VERSION_RESET;
            phase        = PH_CIRCUIT;
            count        = '0;
            cid          = '0;
            cmd          = '0;
            len          = '0;
            errors       = 0;
        endfunction

        function logic [15:0] id_len();
            return (cur_version >= lcd_pkg::LONG_CID_VERSION) ?
                   lcd_pkg::LONG_CID_BYTES : lcd_pkg::SHORT_CID_BYTES;
        endfunction

        function int id_bytes_left();
            return (count >= id_len()) ? 1 : int'(id_len() - count);
        endfunction

        function bit at_cell_start();
            return (phase == PH_CIRCUIT) && (count == 0);
        endfunction

        function void push_item(input logic kind, input logic [7:0] pbyte, input logic last);
            cell_item_t it;
            it.kind  = kind;
            it.cid   = cid;
            it.cmd   = cmd;
            it.len   = len;
            it.pbyte = pbyte;
            it.last  = last;
            due_items = {due_items, it};
        endfunction

        function void open_payload();
            push_item(lcd_pkg::REC_HEADER, 8'h00, len == 0);
            phase = (len == 0) ? PH_CIRCUIT : PH_PAYLOAD;
            count = '0;
        endfunction

        function void take_byte(input logic [7:0] b);
            case (phase)
                PH_COMMAND:
                begin
                    cmd   = b;
                    count = '0;
                    if (is_var_cmd(b))
                        phase = PH_LENGTH;
                    else
                    begin
                        len = lcd_pkg::FIXED_LEN;
                        open_payload();
                    end
                end
                PH_LENGTH:
                begin
                    if (count == 0)
                    begin
                        len   = {b, 8'h00};
                        count = 16'd1;
                    end
                    else
                    begin
                        len[7:0] = b;
                        open_payload();
                    end
                end
                PH_PAYLOAD:
                begin
                    count = count + 16'd1;
                    if (count >= len)
                    begin
                        push_item(lcd_pkg::REC_PAYLOAD, b, 1'b1);
                        phase = PH_CIRCUIT;
                        count = '0;
                    end
                    else
                        push_item(lcd_pkg::REC_PAYLOAD, b, 1'b0);
                end
                default:
                begin
                    cid   = (count == 0) ? {24'h0, b} : {cid[23:0], b};
                    count = count + 16'd1;
                    if (count >= id_len())
                    begin
                        phase = PH_COMMAND;
                        count = '0;
                    end
                end
            endcase
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_item(input cell_item_t got);
            cell_item_t want;
            if (due_items.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected item, expected none actual kind %0d cid %0h",
                         $time, got.kind, got.cid);
                return;
            end
            want = due_items.pop_front();
            check_field("record_kind", want.kind, got.kind);
            check_field("cell_cid", want.cid, got.cid);
            check_field("cell_command", want.cmd, got.cmd);
            check_field("payload_length", want.len, got.len);
            check_field("payload_byte", want.pbyte, got.pbyte);
            check_field("last_of_cell", want.last, got.last);
        endfunction
    endclass

    localparam logic [15:0] VERSION_PLAN[8] = '{16'd0, 16'hFFFF, 16'd3, 16'd4,
                                                16'd1, 16'd0, 16'd2, 16'd5};
    localparam logic [7:0]  FIXED_CMD_PLAN[4] = '{8'd0, 8'd127, 8'd6, 8'd8};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        record_kind;
    logic [31:0] cell_cid;
    logic [7:0]  cell_command;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last_of_cell;

    bit                steady = 1'b0;
    deframe_scoreboard sb     = new();

    link_cell_deframer_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .record_kind    (record_kind),
        .cell_cid       (cell_cid),
        .cell_command   (cell_command),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .last_of_cell   (last_of_cell)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready = steady || ($urandom_range(99) >= 38);

    always @(posedge clk)
    begin : out_monitor
        cell_item_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind  = record_kind;
            got.cid   = cell_cid;
            got.cmd   = cell_command;
            got.len   = payload_length;
            got.pbyte = payload_byte;
            got.last  = last_of_cell;
            sb.check_item(got);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 38)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_byte(b);
        @(negedge clk);
    endtask

    // keeps a stray length high byte small so noise never opens a huge cell
    task automatic send_loose_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (sb.phase == PH_LENGTH && sb.count == 0)
            b = 8'($urandom_range(0, 1));
        send_byte(b);
    endtask

    task automatic finish_cell();
        while (!sb.at_cell_start())
            send_loose_byte();
    endtask

    task automatic send_cell(input logic [31:0] cid, input logic [7:0] cmd,
                             input logic [15:0] len);
        int n;
        n = sb.id_bytes_left();
        for (int i = n - 1; i >= 0; i--)
            send_byte(cid[8*i +: 8]);
        send_byte(cmd);
        if (is_var_cmd(cmd))
        begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else
            len = lcd_pkg::FIXED_LEN;
        repeat (len)
            send_byte(8'($urandom));
    endtask

    task automatic drain(input int settle);
        in_valid = 1'b0;
        while (sb.due_items.size() != 0)
            @(negedge clk);
        repeat (settle)
            @(negedge clk);
    endtask

    task automatic write_version(input logic [15:0] v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.cur_version = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        int          stop_at;
        int          pick;
        logic [31:0] cid;
        logic [7:0]  cmd;
        logic [15:0] len;

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_cell(32'hFFFF_FFFF, lcd_pkg::CMD_VAR_LOW, 16'h0000);
        send_cell(32'h0000_0000, 8'hFF, 16'h0001);
        send_cell(32'h8000_0001, lcd_pkg::CMD_VAR_HIGH_MIN, 16'h0002);

        for (int p = 0; p < 8; p++)
        begin
            // version change lands at a cell edge, mid-id or mid-payload
            stop_at = $urandom_range(2);
            if (stop_at == 1)
                repeat ($urandom_range(1, sb.id_len() - 1))
                    send_byte(8'($urandom));
            else if (stop_at == 2)
            begin
                repeat (sb.id_bytes_left())
                    send_byte(8'($urandom));
                send_byte($urandom_range(1) ? lcd_pkg::CMD_VAR_LOW : 8'd200);
                send_byte(8'h00);
                send_byte(8'($urandom_range(2, 8)));
                send_byte(8'($urandom));
            end
            drain(4);
            write_version((p == 5) ? 16'($urandom) : VERSION_PLAN[p]);
            if (stop_at == 2)
                finish_cell();
            steady = (p == 4);

            if (p % 4 == 0)
                send_cell($urandom, FIXED_CMD_PLAN[$urandom_range(3)], 16'h0000);

            repeat (2)
            begin
                if ($urandom_range(99) < 6)
                begin
                    repeat ($urandom_range(1, 6))
                        send_loose_byte();
                    finish_cell();
                end
                else
                begin
                    pick = $urandom_range(99);
                    cid  = (pick < 8) ? 32'h0 : (pick < 16) ? 32'hFFFF_FFFF : $urandom;
                    cmd  = ($urandom_range(99) < 30) ? lcd_pkg::CMD_VAR_LOW
                                                     : 8'($urandom_range(128, 255));
                    pick = $urandom_range(99);
                    if (pick < 10)
                        len = 16'h0;
                    else if (pick < 94)
                        len = 16'($urandom_range(1, 12));
                    else
                        len = 16'($urandom_range(13, 300));
                    send_cell(cid, cmd, len);
                end
            end
        end

        steady = 1'b0;
        send_cell($urandom, 8'hFF, 16'h0100);
        drain(8);

        if (sb.errors == 0)
            $display("PASS link_cell_deframer_unit");
        else
            $display("FAIL link_cell_deframer_unit");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAIL link_cell_deframer_unit");
        $finish;
    end

endmodule
